// ===== design/lis_pkg.sv =====
// Shared widths and defaults for the longest increasing subsequence block.
package lis_pkg;

    localparam int VALUE_W       = 32;
    localparam int LEN_W         = 11;
    localparam int MAX_ITEMS_DEF = 1024;

endpackage

// ===== design/lis_if.sv =====
// Valid/ready channel interfaces for the input items and the results.
interface lis_in_if
    import lis_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;
    logic                      last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface lis_out_if
    import lis_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] length_here;
    logic [LEN_W-1:0] best_so_far;
    logic             overflow;
    logic             done_res;

    modport source (output valid, output length_here, output best_so_far,
                    output overflow, output done_res, input ready);
    modport sink   (input valid, input length_here, input best_so_far,
                    input overflow, input done_res, output ready);
endinterface

// ===== design/longest_increasing_subsequence.sv =====
// Top level: longest strictly increasing subsequence over a stored sequence.
//
//  channel  | dir | fields                                          | transfer
//  ---------+-----+-------------------------------------------------+-------------
//  i_in     | in  | value[31:0] signed, last                        | valid & ready
//  o_res    | out | length_here[10:0], best_so_far[10:0], overflow, | valid & ready
//           |     | done_res                                        |
//
//  One item at a time. An item is scanned against the N entries stored so far:
//  one read of the entry memory per stored entry, each compared on its registered
//  read data; then the scan is left, and the result is registered and the entry
//  written back. A full store or an empty sequence skips the scan.
//  Reset clears the entry count and the best length; the memory is not cleared.
//  A waiting result holds in the output register; a new item is taken meanwhile,
//  and its write-back waits until that result is transferred.
module longest_increasing_subsequence
    import lis_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lis_in_if.sink      i_in,
    lis_out_if.source   o_res
);

    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam int AW     = $clog2(MAX_ITEMS);
    localparam int ENT_W  = VALUE_W + CNT_W;
    localparam int WIDE_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state                    r_state, n_state;
    logic signed [VALUE_W-1:0] r_value, n_value;
    logic                      r_last, n_last;
    logic                      r_ovf, n_ovf;
    logic [CNT_W-1:0]          r_count, n_count;
    logic [CNT_W-1:0]          r_best, n_best;
    logic [CNT_W-1:0]          r_top, n_top;
    logic [CNT_W-1:0]          r_issue, n_issue;
    logic                      r_rd_vld, n_rd_vld;

    logic                      r_o_valid, n_o_valid;
    logic [LEN_W-1:0]          r_o_len, n_o_len;
    logic [LEN_W-1:0]          r_o_best, n_o_best;
    logic                      r_o_ovf, n_o_ovf;
    logic                      r_o_done, n_o_done;

    // entry memory: {value, length}
    logic [ENT_W-1:0]          mem [MAX_ITEMS];
    logic [ENT_W-1:0]          r_rd_data;
    logic                      rd_en;
    logic [AW-1:0]             rd_addr;
    logic                      wr_en;
    logic [AW-1:0]             wr_addr;
    logic [ENT_W-1:0]          wr_data;

    logic signed [VALUE_W-1:0] rd_val;
    logic [CNT_W-1:0]          rd_len;
    logic [CNT_W-1:0]          here;
    logic [CNT_W-1:0]          best_new;
    logic [WIDE_W-1:0]         here_wide;
    logic [WIDE_W-1:0]         best_wide;
    logic                      out_free;

    assign rd_val    = $signed(r_rd_data[ENT_W-1 -: VALUE_W]);
    assign rd_len    = r_rd_data[CNT_W-1:0];
    assign out_free  = !r_o_valid || o_res.ready;

    assign here      = r_ovf ? '0 : r_top + CNT_W'(1);
    assign best_new  = (here > r_best) ? here : r_best;
    assign here_wide = WIDE_W'(here);
    assign best_wide = WIDE_W'(best_new);

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_res.valid       = r_o_valid;
    assign o_res.length_here = r_o_len;
    assign o_res.best_so_far = r_o_best;
    assign o_res.overflow    = r_o_ovf;
    assign o_res.done_res    = r_o_done;

    always_comb begin
        n_state   = r_state;
        n_value   = r_value;
        n_last    = r_last;
        n_ovf     = r_ovf;
        n_count   = r_count;
        n_best    = r_best;
        n_top     = r_top;
        n_issue   = r_issue;
        n_rd_vld  = 1'b0;
        n_o_valid = r_o_valid && !o_res.ready;
        n_o_len   = r_o_len;
        n_o_best  = r_o_best;
        n_o_ovf   = r_o_ovf;
        n_o_done  = r_o_done;
        rd_en     = 1'b0;
        rd_addr   = r_issue[AW-1:0];
        wr_en     = 1'b0;
        wr_addr   = r_count[AW-1:0];
        wr_data   = {r_value, here};

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_value = i_in.value;
                    n_last  = i_in.last;
                    n_ovf   = (r_count >= CNT_W'(MAX_ITEMS));
                    n_top   = '0;
                    n_issue = '0;
                    if (n_ovf || r_count == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // one read issued per cycle, compared in the cycle after, on the registered read data
                rd_en = (r_issue < r_count);
                if (rd_en) begin
                    n_issue  = r_issue + CNT_W'(1);
                    n_rd_vld = 1'b1;
                end
                if (r_rd_vld && rd_val < r_value && rd_len > r_top) begin
                    n_top = rd_len;
                end
                if (!rd_en && !r_rd_vld) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    wr_en     = !r_ovf;
                    n_o_valid = 1'b1;
                    n_o_len   = here_wide[LEN_W-1:0];
                    n_o_best  = best_wide[LEN_W-1:0];
                    n_o_ovf   = r_ovf;
                    n_o_done  = r_last;
                    if (r_last) begin
                        n_count = '0;
                        n_best  = '0;
                    end else begin
                        n_count = r_ovf ? r_count : r_count + CNT_W'(1);
                        n_best  = best_new;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_best    <= '0;
            r_rd_vld  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_best    <= n_best;
            r_rd_vld  <= n_rd_vld;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value  <= n_value;
        r_last   <= n_last;
        r_ovf    <= n_ovf;
        r_top    <= n_top;
        r_issue  <= n_issue;
        r_o_len  <= n_o_len;
        r_o_best <= n_o_best;
        r_o_ovf  <= n_o_ovf;
        r_o_done <= n_o_done;
    end

endmodule

// ===== design/lis_chk.sv =====
// Port-level checker for the longest increasing subsequence block, with its bind.
module lis_chk
    import lis_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             o_res_valid,
    input logic             o_res_ready,
    input logic [LEN_W-1:0] o_res_length_here,
    input logic             o_res_overflow
);

    // an ignored element never reports a length
    a_ovf_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res_overflow |-> o_res_length_here == '0)
        else $error("overflow result with nonzero length");

    // one item at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken while an item is in work");

    // a result cannot show up the cycle right after its item
    a_no_instant_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !o_res_valid |=> !o_res_valid)
        else $error("result appeared without any work cycle");

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_res_ready |=> o_res_valid)
        else $error("result dropped before transfer");

endmodule

bind longest_increasing_subsequence lis_chk u_lis_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in.valid),
    .i_in_ready        (i_in.ready),
    .o_res_valid       (o_res.valid),
    .o_res_ready       (o_res.ready),
    .o_res_length_here (o_res.length_here),
    .o_res_overflow    (o_res.overflow)
);

// ===== verif/tb_longest_increasing_subsequence.sv =====
// Self-checking testbench for the longest increasing subsequence block.
module tb_longest_increasing_subsequence;
    import lis_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_ITEMS = MAX_ITEMS_DEF;
    localparam int RANDOM_ITEMS = 580;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
        bit                        drain_first;  // hold off until all results are back
    } seq_item_t;

    typedef struct packed {
        logic [LEN_W-1:0] length_here;
        logic [LEN_W-1:0] best_so_far;
        logic             overflow;
        logic             done_res;
    } lis_result_t;

    logic i_clk;
    logic i_rst_n;

    lis_in_if  in_if ();
    lis_out_if res_if ();

    longest_increasing_subsequence #(
        .MAX_ITEMS (MAX_ITEMS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_res   (res_if)
    );

    seq_item_t   value_feed_q[$];
    lis_result_t due_results_q[$];

    // predictor state for the open sequence
    logic signed [VALUE_W-1:0] held_val [MAX_ITEMS];
    int unsigned               held_len [MAX_ITEMS];
    int unsigned               held_n;
    int unsigned               run_best;

    bit          idle_on;
    bit          in_taken;
    int          send_gap;
    int          recv_gap;
    int          n_errors;
    int          n_accepted;
    int          n_results;
    int          n_overflow;
    int          n_sequences;
    int unsigned longest_seen;
    seq_item_t   next_item;
    lis_result_t got;
    lis_result_t want;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic lis_result_t lis_advance(logic signed [VALUE_W-1:0] v, logic fin);
        lis_result_t r;
        int unsigned top;
        r = '0;
        if (held_n >= MAX_ITEMS) begin
            r.overflow = 1'b1;
        end else begin
            top = 0;
            for (int k = 0; k < held_n; k++) begin
                // strict compare: an equal value does not extend a run
                if (held_val[k] < v && held_len[k] > top)
                    top = held_len[k];
            end
            held_val[held_n] = v;
            held_len[held_n] = top + 1;
            held_n++;
            if (top + 1 > run_best)
                run_best = top + 1;
            r.length_here = LEN_W'(top + 1);
        end
        r.best_so_far = LEN_W'(run_best);
        r.done_res    = fin;
        if (fin) begin
            held_n   = 0;
            run_best = 0;
        end
        return r;
    endfunction

    task automatic flag_mismatch(string what, int unsigned got_v, int unsigned want_v);
        n_errors++;
        $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got_v,
                 want_v);
    endtask

    task automatic push_item(logic signed [VALUE_W-1:0] v, logic fin, bit drain = 1'b0);
        seq_item_t it;
        it.value       = v;
        it.last        = fin;
        it.drain_first = drain;
        value_feed_q.push_back(it);
    endtask

    // One sequence of random content; style picks the value distribution.
    task automatic push_sequence(int len, int style, bit drain);
        logic signed [VALUE_W-1:0] v;
        logic signed [VALUE_W-1:0] trend;
        trend = $urandom_range(0, 2000) - 1000;
        for (int k = 0; k < len; k++) begin
            case (style)
                0: v = $urandom;
                1: v = $urandom_range(0, 15) - 8;
                2: begin
                    trend = trend + ($urandom_range(0, 20) - 6);
                    v = trend;
                end
                default: begin
                    case ($urandom_range(0, 5))
                        0: v = 32'sh8000_0000;
                        1: v = 32'sh7FFF_FFFF;
                        2: v = 0;
                        3: v = -1;
                        4: v = 1;
                        default: v = $urandom;
                    endcase
                end
            endcase
            push_item(v, k == len - 1, drain && k == 0);
        end
    endtask

    // Acceptance, prediction and result checking, all on the rising edge.
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && in_if.valid && in_if.ready;
        if (i_rst_n && in_if.valid && in_if.ready) begin
            due_results_q.push_back(lis_advance(in_if.value, in_if.last));
            n_accepted++;
        end
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got.length_here = res_if.length_here;
            got.best_so_far = res_if.best_so_far;
            got.overflow    = res_if.overflow;
            got.done_res    = res_if.done_res;
            n_results++;
            if (due_results_q.size() == 0) begin
                flag_mismatch("unexpected result", 1, 0);
            end else begin
                want = due_results_q.pop_front();
                if (got.length_here !== want.length_here)
                    flag_mismatch("length_here", got.length_here, want.length_here);
                if (got.best_so_far !== want.best_so_far)
                    flag_mismatch("best_so_far", got.best_so_far, want.best_so_far);
                if (got.overflow !== want.overflow)
                    flag_mismatch("overflow", got.overflow, want.overflow);
                if (got.done_res !== want.done_res)
                    flag_mismatch("done_res", got.done_res, want.done_res);
                if (want.overflow)
                    n_overflow++;
                if (want.done_res)
                    n_sequences++;
                if (want.length_here > longest_seen)
                    longest_seen = want.length_here;
            end
        end
    end

    // Input driver.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_taken) begin
            if (send_gap > 0) begin
                send_gap = send_gap - 1;
                in_if.valid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                send_gap = $urandom_range(0, 18);
                in_if.valid <= 1'b0;
            end else if (value_feed_q.size() > 0 &&
                         !(value_feed_q[0].drain_first && due_results_q.size() != 0)) begin
                next_item = value_feed_q.pop_front();
                in_if.valid <= 1'b1;
                in_if.value <= next_item.value;
                in_if.last  <= next_item.last;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Result side back-pressure.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap = recv_gap - 1;
            res_if.ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            recv_gap = $urandom_range(0, 18);
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    initial begin
        #50ms;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        logic signed [VALUE_W-1:0] ramp;
        int n_random;
        int chunk;
        int len;

        in_if.valid  = 1'b0;
        in_if.value  = '0;
        in_if.last   = 1'b0;
        res_if.ready = 1'b0;
        i_rst_n      = 1'b0;
        idle_on      = 1'b0;
        held_n       = 0;
        run_best     = 0;
        n_random     = 0;
        chunk        = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: single element, extremes with equal values, falling, rising
        push_item(0, 1'b1);
        push_item(32'sh8000_0000, 1'b0);
        push_item(32'sh7FFF_FFFF, 1'b0);
        push_item(0, 1'b0);
        push_item(0, 1'b0);
        push_item(1, 1'b0);
        push_item(-1, 1'b0);
        push_item(32'sh7FFF_FFFF, 1'b0);
        push_item(32'sh8000_0000, 1'b1);
        for (int k = 5; k >= 1; k--)
            push_item(k, k == 1);
        for (int k = -3; k <= 2; k++)
            push_item(k, k == 2);
        while (value_feed_q.size() != 0) @(posedge i_clk);

        // random: short sequences mostly, idling on in two chunks of three
        while (n_random < RANDOM_ITEMS) begin
            idle_on = (chunk % 3 != 2);
            for (int s = 0; s < 6; s++) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 60)
                                                  : $urandom_range(1, 16);
                push_sequence(len, $urandom_range(0, 3), chunk == 1 && s == 0);
                n_random += len;
            end
            while (value_feed_q.size() != 0) @(posedge i_clk);
            chunk++;
        end

        // last part, no idling: fill the store with a strictly rising run,
        // then overflow, with last landing on an ignored element
        idle_on = 1'b0;
        ramp = 32'sh8000_0000;
        for (int k = 0; k < MAX_ITEMS; k++) begin
            push_item(ramp, 1'b0);
            ramp = ramp + $urandom_range(1, 4_000_000);
        end
        push_item($urandom, 1'b0);
        push_item(32'sh7FFF_FFFF, 1'b0);
        push_item($urandom, 1'b1);
        push_item(7, 1'b0);
        push_item(8, 1'b0);
        push_item(8, 1'b1);

        while (value_feed_q.size() != 0 || in_if.valid || due_results_q.size() != 0)
            @(posedge i_clk);
        repeat (MAX_ITEMS + 8) @(posedge i_clk);

        $display("Ran %0d items over %0d sequences; %0d overflowed, longest run %0d.",
                 n_accepted, n_sequences, n_overflow, longest_seen);
        $display("Results checked: %0d, mismatches: %0d.", n_results, n_errors);
        if (n_errors == 0 && due_results_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/lis_pkg.sv
design/lis_if.sv
design/longest_increasing_subsequence.sv
design/lis_chk.sv
verif/tb_longest_increasing_subsequence.sv
